// ===== src/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg - shared definitions for the Playfair digraph cipher core
// Widths, item kinds, letter codes, control/status structs and the small
// square geometry helpers used by the datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int NLET     = 26;
    localparam int LW       = $clog2(NLET);
    localparam int CW       = $clog2(CELLS);
    localparam int FW       = $clog2(CELLS + 1);
    localparam int RW       = $clog2(SIDE);
    localparam int CHAR_W   = 8;
    localparam int LETTER_W = 7;
    localparam int KIND_W   = 2;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    typedef logic [LW-1:0] t_letter;
    typedef logic [CW-1:0] t_cell;
    typedef logic [FW-1:0] t_fill;
    typedef logic [RW-1:0] t_rc;

    localparam logic [KIND_W-1:0] KIND_KEY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd3;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam t_letter LET_I    = t_letter'(8);
    localparam t_letter LET_J    = t_letter'(9);
    localparam t_letter LET_X    = t_letter'(23);
    localparam t_letter LET_LAST = t_letter'(NLET - 1);

    localparam logic [CHAR_W-1:0]   CHAR_UA  = 8'h41;
    localparam logic [CHAR_W-1:0]   CHAR_UZ  = 8'h5A;
    localparam logic [CHAR_W-1:0]   CHAR_LA  = 8'h61;
    localparam logic [CHAR_W-1:0]   CHAR_LZ  = 8'h7A;
    localparam logic [CHAR_W-1:0]   CASE_GAP = 8'd32;
    localparam logic [LETTER_W-1:0] ASCII_A  = 7'h41;

    localparam logic [APB_AW-1:0] ADDR_MODE = 2'd0;

    typedef struct packed {
        logic latch;
        logic exec;
        logic fill_step;
        logic pos_rd;
        logic sq_rd;
        logic load1;
        logic load2;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              closed;
        logic              scan_last;
        logic              pair_go;
        logic              out_free;
    } t_sts;

    // letter held by a cell of the plain square (J skipped)
    function automatic t_letter plain_letter(input t_cell c);
        t_letter l;
        l = t_letter'(c);
        if (l >= LET_J) l = l + t_letter'(1);
        return l;
    endfunction

    // cell of a letter in the plain square, J shares the cell of I
    function automatic t_cell plain_cell(input t_letter l);
        return (l > LET_I) ? t_cell'(l - t_letter'(1)) : t_cell'(l);
    endfunction

    function automatic t_cell cell_at(input t_rc r, input t_rc c);
        return t_cell'(int'(r) * SIDE + int'(c));
    endfunction

    function automatic t_rc cell_row(input t_cell p);
        t_rc r;
        r = '0;
        for (int k = 1; k < SIDE; k++) begin
            if (p >= t_cell'(k * SIDE)) r = t_rc'(k);
        end
        return r;
    endfunction

    function automatic t_rc cell_col(input t_cell p);
        t_rc r;
        r = cell_row(p);
        return t_rc'(p - cell_at(r, '0));
    endfunction

    // cyclic step: +1 for encrypt, -1 for decrypt
    function automatic t_rc step_rc(input t_rc v, input logic dec);
        t_rc s;
        if (dec == MODE_DEC) begin
            s = (v == '0) ? t_rc'(SIDE - 1) : v - t_rc'(1);
        end else begin
            s = (v == t_rc'(SIDE - 1)) ? '0 : v + t_rc'(1);
        end
        return s;
    endfunction

endpackage

// ===== src/pfc_in_if.sv =====
// ----------------------------------------------------------------------------
// pfc_in_if - input item channel
// valid/ready handshake carrying the item kind and the raw byte.
// ----------------------------------------------------------------------------
interface pfc_in_if import pfc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

// ===== src/pfc_out_if.sv =====
// ----------------------------------------------------------------------------
// pfc_out_if - result letter channel
// valid/ready handshake carrying one output letter and the pair-end flag.
// ----------------------------------------------------------------------------
interface pfc_out_if import pfc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last;

    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

// ===== src/pfc_ram.sv =====
// ----------------------------------------------------------------------------
// pfc_ram - generic RAM
// One write port, two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/pfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfc_ctrl - sequencer for the Playfair core
// Takes one item at a time, runs the key fill walk and the pair lookups,
// and hands the two result letters to the output register.
// ----------------------------------------------------------------------------
module pfc_ctrl import pfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_POS   = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_EMIT1 = 3'd5;
    localparam logic [2:0] S_EMIT2 = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.kind == KIND_KEY) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end else if (!i_sts.closed) begin
                    n_state = S_FILL;
                end else if (i_sts.kind == KIND_KEY_END) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.pair_go ? S_POS : S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.scan_last) n_state = S_EXEC;
            end
            S_POS: begin
                o_cmd.pos_rd = 1'b1;
                n_state      = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_rd = 1'b1;
                n_state     = S_EMIT1;
            end
            S_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.load1 = 1'b1;
                    n_state     = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (i_sts.out_free) begin
                    o_cmd.load2 = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/pfc_dp.sv =====
// ----------------------------------------------------------------------------
// pfc_dp - datapath for the Playfair core
// Key state, square and position memories, pairing logic, pair rules and
// the output register.
// ----------------------------------------------------------------------------
module pfc_dp import pfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mode,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [CHAR_W-1:0]   i_char,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [LETTER_W-1:0] o_out_letter,
    output logic                o_out_last
);

    logic [KIND_W-1:0]   r_kind,  n_kind;
    logic [CHAR_W-1:0]   r_char,  n_char;
    logic [NLET-1:0]     r_used,  n_used;
    t_fill               r_fill,  n_fill;
    logic                r_closed, n_closed;
    logic                r_plain, n_plain;
    t_letter             r_prev,  n_prev;
    logic                r_prev_v, n_prev_v;
    t_letter             r_pend,  n_pend;
    logic                r_pend_v, n_pend_v;
    t_letter             r_scan,  n_scan;
    t_letter             r_a,     n_a;
    t_letter             r_b,     n_b;
    t_cell               r_o1,    n_o1;
    t_cell               r_o2,    n_o2;
    logic                r_out_v, n_out_v;
    logic [LETTER_W-1:0] r_out_letter, n_out_letter;
    logic                r_out_last,   n_out_last;

    logic [CHAR_W-1:0] up;
    logic              is_let;
    t_letter           fl;
    t_letter           kl;
    logic [NLET-1:0]   base_used;
    t_fill             base_fill;
    logic              t_go;
    t_letter           pa;
    t_letter           pb;
    logic              wr_en;
    t_cell             wr_cell;
    t_letter           wr_letter;
    t_cell             pos_rd_a, pos_rd_b;
    t_letter           sq_rd_a, sq_rd_b;
    t_letter           pos_addr_a, pos_addr_b;
    t_cell             p1, p2;
    t_rc               r1, c1, r2, c2;
    t_cell             o1, o2;
    t_letter           l1, l2;

    // case fold and letter number
    always_comb begin
        up     = (r_char >= CHAR_LA && r_char <= CHAR_LZ) ? r_char - CASE_GAP : r_char;
        is_let = (up >= CHAR_UA) && (up <= CHAR_UZ);
        fl     = t_letter'(up - CHAR_UA);
        kl     = (fl == LET_J) ? LET_I : fl;
    end

    assign base_used = r_closed ? '0 : r_used;
    assign base_fill = r_closed ? '0 : r_fill;

    // pairing decision for text and flush items
    always_comb begin
        t_go = 1'b0;
        pa   = r_pend;
        pb   = LET_X;
        if (r_kind == KIND_FLUSH) begin
            t_go = r_pend_v;
        end else if (is_let) begin
            if (i_mode == MODE_ENC && r_prev_v && r_prev == fl) begin
                t_go = 1'b1;
                if (!r_pend_v) begin
                    pa = LET_X;
                    pb = fl;
                end
            end else begin
                t_go = r_pend_v;
                pb   = fl;
            end
        end
    end

    // pair rules
    assign pos_addr_a = (r_a == LET_J) ? LET_I : r_a;
    assign pos_addr_b = (r_b == LET_J) ? LET_I : r_b;

    always_comb begin
        p1 = r_plain ? plain_cell(r_a) : pos_rd_a;
        p2 = r_plain ? plain_cell(r_b) : pos_rd_b;
        r1 = cell_row(p1);
        c1 = cell_col(p1);
        r2 = cell_row(p2);
        c2 = cell_col(p2);
        if (r1 == r2) begin
            o1 = cell_at(r1, step_rc(c1, i_mode));
            o2 = cell_at(r2, step_rc(c2, i_mode));
        end else if (c1 == c2) begin
            o1 = cell_at(step_rc(r1, i_mode), c1);
            o2 = cell_at(step_rc(r2, i_mode), c2);
        end else begin
            o1 = cell_at(r1, c2);
            o2 = cell_at(r2, c1);
        end
    end

    assign l1 = r_plain ? plain_letter(r_o1) : sq_rd_a;
    assign l2 = r_plain ? plain_letter(r_o2) : sq_rd_b;

    always_comb begin
        n_kind       = r_kind;
        n_char       = r_char;
        n_used       = r_used;
        n_fill       = r_fill;
        n_closed     = r_closed;
        n_plain      = r_plain;
        n_prev       = r_prev;
        n_prev_v     = r_prev_v;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_scan       = r_scan;
        n_a          = r_a;
        n_b          = r_b;
        n_o1         = r_o1;
        n_o2         = r_o2;
        n_out_letter = r_out_letter;
        n_out_last   = r_out_last;
        n_out_v      = i_out_ready ? 1'b0 : r_out_v;
        wr_en        = 1'b0;
        wr_cell      = base_fill[CW-1:0];
        wr_letter    = kl;

        if (i_cmd.latch) begin
            n_kind = i_kind;
            n_char = i_char;
            n_scan = '0;
        end

        if (i_cmd.exec) begin
            n_a = pa;
            n_b = pb;
            unique case (r_kind)
                KIND_KEY: begin
                    if (r_closed) begin
                        n_closed = 1'b0;
                        n_prev_v = 1'b0;
                        n_pend_v = 1'b0;
                    end
                    n_plain = 1'b0;
                    n_used  = base_used;
                    n_fill  = base_fill;
                    if (is_let && !base_used[kl]) begin
                        n_used = base_used | (NLET'(1) << kl);
                        if (base_fill < t_fill'(CELLS)) begin
                            wr_en  = 1'b1;
                            n_fill = base_fill + t_fill'(1);
                        end
                    end
                end
                KIND_TEXT: begin
                    if (is_let) begin
                        n_prev   = fl;
                        n_prev_v = 1'b1;
                        if (i_mode == MODE_ENC && r_prev_v && r_prev == fl) begin
                            if (r_pend_v) n_pend = fl;
                        end else if (r_pend_v) begin
                            n_pend_v = 1'b0;
                        end else begin
                            n_pend   = fl;
                            n_pend_v = 1'b1;
                        end
                    end
                end
                KIND_FLUSH: begin
                    n_pend_v = 1'b0;
                    n_prev_v = 1'b0;
                end
                KIND_KEY_END: begin
                    n_closed = r_closed;
                end
                default: begin
                    n_closed = r_closed;
                end
            endcase
        end

        // fill walk: one letter of the alphabet per cycle
        if (i_cmd.fill_step) begin
            wr_letter = r_scan;
            wr_cell   = r_fill[CW-1:0];
            if (r_scan != LET_J && !r_used[r_scan]) begin
                n_used[r_scan] = 1'b1;
                if (r_fill < t_fill'(CELLS)) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + t_fill'(1);
                end
            end
            n_scan = r_scan + t_letter'(1);
            if (r_scan == LET_LAST) n_closed = 1'b1;
        end

        if (i_cmd.sq_rd) begin
            n_o1 = o1;
            n_o2 = o2;
        end

        if (i_cmd.load1) begin
            n_out_v      = 1'b1;
            n_out_letter = ASCII_A + LETTER_W'(l1);
            n_out_last   = 1'b0;
        end else if (i_cmd.load2) begin
            n_out_v      = 1'b1;
            n_out_letter = ASCII_A + LETTER_W'(l2);
            n_out_last   = 1'b1;
        end
    end

    pfc_ram #(
        .WIDTH (LW),
        .DEPTH (CELLS)
    ) u_square (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_cell),
        .i_wdata   (wr_letter),
        .i_re      (i_cmd.sq_rd),
        .i_raddr_a (o1),
        .i_raddr_b (o2),
        .o_rdata_a (sq_rd_a),
        .o_rdata_b (sq_rd_b)
    );

    pfc_ram #(
        .WIDTH (CW),
        .DEPTH (NLET)
    ) u_position (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_letter),
        .i_wdata   (wr_cell),
        .i_re      (i_cmd.pos_rd),
        .i_raddr_a (pos_addr_a),
        .i_raddr_b (pos_addr_b),
        .o_rdata_a (pos_rd_a),
        .o_rdata_b (pos_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_fill   <= '0;
            r_closed <= 1'b1;
            r_plain  <= 1'b1;
            r_prev_v <= 1'b0;
            r_pend_v <= 1'b0;
            r_scan   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_fill   <= n_fill;
            r_closed <= n_closed;
            r_plain  <= n_plain;
            r_prev_v <= n_prev_v;
            r_pend_v <= n_pend_v;
            r_scan   <= n_scan;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_char       <= n_char;
        r_prev       <= n_prev;
        r_pend       <= n_pend;
        r_a          <= n_a;
        r_b          <= n_b;
        r_o1         <= n_o1;
        r_o2         <= n_o2;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.closed    = r_closed;
    assign o_sts.scan_last = (r_scan == LET_LAST);
    assign o_sts.pair_go   = t_go && (r_kind == KIND_TEXT || r_kind == KIND_FLUSH);
    assign o_sts.out_free  = !r_out_v || i_out_ready;

    assign o_out_valid  = r_out_v;
    assign o_out_letter = r_out_letter;
    assign o_out_last   = r_out_last;

endmodule

// ===== src/playfair_digraph_cipher_core.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core - Playfair cipher over a 5x5 letter square
// Builds the square from key bytes and turns text letters into cipher or
// plain letter pairs; one mode register on an APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : items {kind, char_code}. Kind key byte, key end, text byte or
//           text end. One item is taken at a time; ready is high only while
//           the core is idle.
//   o_out : result letters, two per finished pair, the second with last=1.
//           An output register holds the current letter, so the next item
//           is taken while the second letter of a pair still waits.
//   APB   : register 0 (mode) at address 0: 0 encrypt, 1 decrypt. Users
//           write it only while the core is idle; it is not enforced.
// Steps per item:
//   key byte, or item that yields no letters: accept, then decode.
//   text item that completes a pair: accept, decode, position read,
//     square read, then each letter, held while the sink stalls.
//   key end, or first text item after a key: first a fill walk, which
//     scans A..Z one letter per cycle into the square memory. Pairs use
//   two registered memory reads (position, then square), two ports each.
// Reset: square is the plain alphabet (served from logic until a new key
//   starts), key closed, nothing pending, mode encrypt. No clearing pass.
// A stalled receiver holds the pair in the emit states; nothing is dropped.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core import pfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfc_in_if.sink            i_in,
    pfc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic r_mode;
    logic n_mode;
    logic cfg_wr;
    t_cmd w_cmd;
    t_sts w_sts;

    // config port: zero wait states, only the mode register is decoded
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MODE);
    assign n_mode = cfg_wr ? pwdata[0] : r_mode;
    assign prdata = (paddr == ADDR_MODE) ? APB_DW'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
        end else begin
            r_mode <= n_mode;
        end
    end

    // sequencer: owns the input handshake and issues datapath commands
    pfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: key state, memories, pair rules, output register
    pfc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_kind       (i_in.kind),
        .i_char       (i_in.char_code),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_letter (o_out.letter),
        .o_out_last   (o_out.last)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.latch, w_cmd.exec, w_cmd.fill_step, w_cmd.pos_rd,
                  w_cmd.sq_rd, w_cmd.load1, w_cmd.load2}))
        else $error("more than one datapath command");

    // an accepted item is decoded before any letter is loaded
    a_accept_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !(w_cmd.load1 || w_cmd.load2))
        else $error("letter loaded right after a transfer in");

    // second letter of a pair shows up with last set
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load2 |=> (o_out.valid && o_out.last))
        else $error("second letter missing or without last");

    // the key opens only on a key byte
    a_key_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_sts.closed) |-> $past(w_cmd.exec && w_sts.kind == KIND_KEY))
        else $error("key opened by something other than a key byte");

endmodule

// ===== bench/tb_playfair_digraph_cipher_core.sv =====
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher_core - self-checking bench for the Playfair core
// Runs a short table of directed items, some with hand-worked letters, then
// random key and text traffic checked against an in-bench cipher predictor.
// Both channels stall at random and the mode register is rewritten while the
// core is idle.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher_core;
    import pfc_pkg::*;

    localparam int SETTLE       = 40;    // fill walk plus pair latency, rounded up
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
    localparam int RANDOM_ITEMS = 860;   // random items after the table

    // table row kinds
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_MODE = 1'b1;

    // One row of the directed table. fixed rows carry hand-worked results
    // (nres letters, l0 then l1); the others are left to the predictor.
    // For a mode row the new mode sits in ch[0].
    typedef struct packed {
        logic              op;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic              fixed;
        logic [1:0]        nres;
        logic [7:0]        l0;
        logic [7:0]        l1;
    } t_plan_row;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_due_letter;

    // Plain square after reset:  ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
    localparam int PLAN_LEN = 32;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{ROW_MODE, KIND_KEY,     8'd0,  1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "A",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "b",   1'b1, 2'd2, "B",   "C"  }, // row rule
        '{ROW_ITEM, KIND_TEXT,    "B",   1'b1, 2'd2, "W",   "C"  }, // X before B
        '{ROW_ITEM, KIND_TEXT,    8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "Z",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "z",   1'b1, 2'd2, "V",   "Y"  }, // Z,X; Z kept
        '{ROW_ITEM, KIND_FLUSH,   8'h00, 1'b1, 2'd2, "V",   "Y"  }, // pad with X
        '{ROW_ITEM, KIND_FLUSH,   8'hFF, 1'b1, 2'd0, 8'h00, 8'h00}, // nothing left
        '{ROW_ITEM, KIND_TEXT,    "A",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "F",   1'b1, 2'd2, "F",   "L"  }, // column rule
        '{ROW_ITEM, KIND_TEXT,    "J",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "I",   1'b1, 2'd2, "K",   "K"  }, // same cell
        '{ROW_ITEM, KIND_TEXT,    "Q",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_MODE, KIND_KEY,     8'd1,  1'b0, 2'd0, 8'h00, 8'h00}, // mid-pair
        '{ROW_ITEM, KIND_TEXT,    "Q",   1'b1, 2'd2, "U",   "U"  }, // no X in decrypt
        '{ROW_ITEM, KIND_TEXT,    "M",   1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY,     "p",   1'b0, 2'd0, 8'h00, 8'h00}, // drops pending M
        '{ROW_ITEM, KIND_KEY,     "A",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY,     8'h20, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY,     "J",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY,     "i",   1'b0, 2'd0, 8'h00, 8'h00}, // repeat of I
        '{ROW_ITEM, KIND_KEY_END, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY_END, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00}, // already closed
        '{ROW_ITEM, KIND_TEXT,    "x",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "y",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_MODE, KIND_KEY,     8'd0,  1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_KEY,     "k",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_TEXT,    "e",   1'b0, 2'd0, 8'h00, 8'h00}, // fill runs first
        '{ROW_ITEM, KIND_TEXT,    "e",   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_ITEM, KIND_FLUSH,   8'h00, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pfc_in_if  item_ch ();
    pfc_out_if letter_ch ();

    playfair_digraph_cipher_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (letter_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Cipher predictor state: the bench's own copy of the square, the
    // letter-to-cell map, key build progress, pairing state and mode.
    // ------------------------------------------------------------------
    t_letter         pf_square [CELLS];
    t_cell           pf_cell [NLET];
    logic [NLET-1:0] pf_used;
    int              pf_fill;
    logic            pf_closed;
    t_letter         pf_prev;
    logic            pf_prev_v;
    t_letter         pf_pend;
    logic            pf_pend_v;
    logic            pf_mode;
    t_due_letter     pf_res [2];     // letters of the last predicted item
    int              pf_nres;
    logic            pf_ignored;     // last item had no effect, but for closing a key

    t_due_letter due_letters [$];    // cipher letters still owed by the core

    int n_errors      = 0;
    int n_items       = 0;
    int n_effective   = 0;
    int n_letters     = 0;
    int n_keys        = 0;
    int n_mode_writes = 0;
    bit calm          = 1'b0;        // no idling on either side while set

    task automatic flag_mismatch(input string msg);
        n_errors++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic void reset_cipher();
        int k;
        k = 0;
        for (int l = 0; l < NLET; l++) begin
            if (l == int'(LET_J)) continue;
            pf_square[k] = t_letter'(l);
            pf_cell[l]   = t_cell'(k);
            k++;
        end
        pf_cell[LET_J] = pf_cell[LET_I];
        pf_used   = '0;
        pf_fill   = 0;
        pf_closed = 1'b1;
        pf_prev   = '0;
        pf_prev_v = 1'b0;
        pf_pend   = '0;
        pf_pend_v = 1'b0;
        pf_mode   = MODE_ENC;
    endfunction

    // letter number 0..25, or -1 for anything that is not a letter
    function automatic int fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = c;
        if (u >= CHAR_LA && u <= CHAR_LZ) u = u - CASE_GAP;
        if (u >= CHAR_UA && u <= CHAR_UZ) return int'(u - CHAR_UA);
        return -1;
    endfunction

    function automatic void add_key_letter(input int l);
        if (pf_fill < CELLS) begin
            pf_square[pf_fill] = t_letter'(l);
            pf_fill++;
        end
        pf_used[l] = 1'b1;
    endfunction

    // append the unused letters, then rebuild the letter-to-cell map
    function automatic void close_square();
        for (int l = 0; l < NLET; l++) begin
            if (l != int'(LET_J) && !pf_used[l]) add_key_letter(l);
        end
        for (int k = 0; k < CELLS; k++) pf_cell[pf_square[k]] = t_cell'(k);
        pf_cell[LET_J] = pf_cell[LET_I];
        pf_closed = 1'b1;
        n_keys++;
    endfunction

    function automatic void pair_out(input int a, input int b);
        int p1, p2, r1, c1, r2, c2, d, o1, o2;
        p1 = int'(pf_cell[a]);
        p2 = int'(pf_cell[b]);
        r1 = p1 / SIDE;
        c1 = p1 % SIDE;
        r2 = p2 / SIDE;
        c2 = p2 % SIDE;
        d  = (pf_mode == MODE_DEC) ? SIDE - 1 : 1;
        if (r1 == r2) begin
            o1 = r1 * SIDE + (c1 + d) % SIDE;
            o2 = r2 * SIDE + (c2 + d) % SIDE;
        end else if (c1 == c2) begin
            o1 = ((r1 + d) % SIDE) * SIDE + c1;
            o2 = ((r2 + d) % SIDE) * SIDE + c2;
        end else begin
            o1 = r1 * SIDE + c2;
            o2 = r2 * SIDE + c1;
        end
        pf_res[0] = t_due_letter'{LETTER_W'(int'(ASCII_A) + int'(pf_square[o1])), 1'b0};
        pf_res[1] = t_due_letter'{LETTER_W'(int'(ASCII_A) + int'(pf_square[o2])), 1'b1};
        pf_nres   = 2;
    endfunction

    // advance the predictor by one accepted item; results land in pf_res
    function automatic void cipher_step(input logic [KIND_W-1:0] kind,
                                        input logic [CHAR_W-1:0] ch);
        int l;
        pf_nres    = 0;
        pf_ignored = 1'b0;
        l = fold_char(ch);
        if (kind == KIND_KEY) begin
            if (pf_closed) begin
                // first byte of a fresh key wipes the key and the text state
                pf_used   = '0;
                pf_fill   = 0;
                pf_closed = 1'b0;
                pf_prev_v = 1'b0;
                pf_pend_v = 1'b0;
            end
            if (l == int'(LET_J)) l = int'(LET_I);
            if (l >= 0 && !pf_used[l]) add_key_letter(l);
            return;
        end
        if (kind == KIND_KEY_END) begin
            if (!pf_closed) close_square();
            else pf_ignored = 1'b1;
            return;
        end
        if (!pf_closed) close_square();
        if (kind == KIND_FLUSH) begin
            if (pf_pend_v) pair_out(int'(pf_pend), int'(LET_X));
            pf_pend_v = 1'b0;
            pf_prev_v = 1'b0;
            return;
        end
        if (l < 0) begin
            pf_ignored = 1'b1;
            return;
        end
        if (pf_mode == MODE_ENC && pf_prev_v && int'(pf_prev) == l) begin
            // doubled raw letter: X goes between the two
            if (pf_pend_v) begin
                pair_out(int'(pf_pend), int'(LET_X));
                pf_pend = t_letter'(l);
            end else begin
                pair_out(int'(LET_X), l);
            end
            pf_prev = t_letter'(l);
            return;
        end
        pf_prev   = t_letter'(l);
        pf_prev_v = 1'b1;
        if (pf_pend_v) begin
            pf_pend_v = 1'b0;
            pair_out(int'(pf_pend), l);
            return;
        end
        pf_pend   = t_letter'(l);
        pf_pend_v = 1'b1;
    endfunction

    function automatic t_plan_row loose_item(input logic [KIND_W-1:0] kind,
                                             input logic [CHAR_W-1:0] ch);
        return t_plan_row'{ROW_ITEM, kind, ch, 1'b0, 2'd0, 8'h00, 8'h00};
    endfunction

    function automatic logic [CHAR_W-1:0] letter_byte(input int l, input logic lower);
        return CHAR_W'(int'(CHAR_UA) + l + (lower ? int'(CASE_GAP) : 0));
    endfunction

    // ------------------------------------------------------------------
    // Item sender. Entered and left at a falling edge. valid is left high
    // on return so a back-to-back item keeps it up with no glitch; anyone
    // who stops sending drops it first.
    // ------------------------------------------------------------------
    task automatic send_item(input t_plan_row r);
        if (!calm) begin
            while ($urandom_range(99) < 26) begin
                item_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= r.kind;
        item_ch.char_code <= r.ch;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        // transfer at this edge: predict before any result can show up
        cipher_step(r.kind, r.ch);
        n_items++;
        if (!pf_ignored) n_effective++;
        if (r.fixed) begin
            if (r.nres != 2'd0) begin
                due_letters.push_back(t_due_letter'{r.l0[LETTER_W-1:0], 1'b0});
                due_letters.push_back(t_due_letter'{r.l1[LETTER_W-1:0], 1'b1});
            end
        end else begin
            for (int k = 0; k < pf_nres; k++) due_letters.push_back(pf_res[k]);
        end
        @(negedge i_clk);
    endtask

    // stop sending, wait for every owed letter, then let any fill walk or
    // letterless item finish inside the core
    task automatic settle_core();
        item_ch.valid <= 1'b0;
        while (due_letters.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write of the mode register, then a read back of it
    task automatic write_mode(input logic m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= APB_DW'(m);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pf_mode = m;
        n_mode_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(pf_mode))
            flag_mismatch($sformatf("mode reads back %0h, wrote %0h", prdata, pf_mode));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Letter sink: stalls about a quarter of the cycles outside the calm stretch.
    initial begin
        letter_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            letter_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // Letter checker: every transfer is matched against the oldest owed letter.
    always @(posedge i_clk) begin
        t_due_letter want;
        if (letter_ch.valid && letter_ch.ready) begin
            n_letters++;
            if (due_letters.size() == 0) begin
                flag_mismatch($sformatf("letter %c arrived with none owed",
                                        letter_ch.letter));
            end else begin
                want = due_letters.pop_front();
                if (letter_ch.letter !== want.letter)
                    flag_mismatch($sformatf("letter %c, expected %c",
                                            letter_ch.letter, want.letter));
                if (letter_ch.last !== want.last)
                    flag_mismatch($sformatf("last %0b on letter %c, expected %0b",
                                            letter_ch.last, want.letter, want.last));
            end
        end
    end

    // Watchdog: any transfer on either channel, or APB activity, restarts it.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (letter_ch.valid && letter_ch.ready) ||
                psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int len;
        int l;
        int prev_l;
        int base;
        logic [CHAR_W-1:0] c;

        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_KEY;
        item_ch.char_code = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        reset_cipher();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed table ------------------------------------------
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].op == ROW_MODE) begin
                settle_core();
                write_mode(PLAN[i].ch[0]);
            end else begin
                send_item(PLAN[i]);
            end
        end

        // ---- random traffic ------------------------------------------
        // Mostly text messages, with keys, mode changes,
        // stray key ends and flushes, and raw noise items mixed in.
        base = n_items;
        while (n_items - base < RANDOM_ITEMS) begin
            calm = (n_items - base >= 350) && (n_items - base < 550);
            pick = $urandom_range(99);
            if (pick < 10) begin
                len = $urandom_range(12, 1);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(9) == 0) c = CHAR_W'($urandom);
                    else c = letter_byte($urandom_range(25), 1'($urandom_range(1)));
                    send_item(loose_item(KIND_KEY, c));
                end
                // sometimes leave the key open so the first text item closes it
                if ($urandom_range(3) != 0)
                    send_item(loose_item(KIND_KEY_END, CHAR_W'($urandom)));
            end else if (pick < 14) begin
                settle_core();
                write_mode(1'($urandom_range(1)));
            end else if (pick < 19) begin
                len = $urandom_range(4, 1);
                for (int j = 0; j < len; j++)
                    send_item(loose_item(KIND_W'($urandom_range(3)), CHAR_W'($urandom)));
            end else begin
                len    = $urandom_range(24, 1);
                prev_l = $urandom_range(25);
                for (int j = 0; j < len; j++) begin
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        c = CHAR_W'($urandom);
                    end else begin
                        // a fifth of the letters repeat the one before
                        l      = (pick >= 80) ? prev_l : int'($urandom_range(25));
                        prev_l = l;
                        c      = letter_byte(l, 1'($urandom_range(1)));
                    end
                    send_item(loose_item(KIND_TEXT, c));
                end
                if ($urandom_range(4) != 0)
                    send_item(loose_item(KIND_FLUSH, CHAR_W'($urandom)));
            end
        end
        calm = 1'b0;

        settle_core();
        $display("run: %0d items sent (%0d changed state), %0d keys built, %0d mode writes",
                 n_items, n_effective, n_keys, n_mode_writes);
        $display("run: %0d cipher letters checked, %0d mismatches", n_letters, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== playfair_digraph_cipher_core.f =====
src/pfc_pkg.sv
src/pfc_in_if.sv
src/pfc_out_if.sv
src/pfc_ram.sv
src/pfc_ctrl.sv
src/pfc_dp.sv
src/playfair_digraph_cipher_core.sv
bench/tb_playfair_digraph_cipher_core.sv
